// ----- rtl/core/i8fcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8fcl_pkg
// Shared types and constants of the int8 fully connected layer engine.
// ----------------------------------------------------------------------------
package i8fcl_pkg;

    // store depth and neuron limit
    localparam int MAX_VECTOR  = 1024;
    localparam int MAX_NEURONS = 1024;

    // field widths
    localparam int ADDR_W = 10;   // activation store address
    localparam int LEN_W  = 11;   // length and count registers
    localparam int NPOS_W = 10;   // neuron position
    localparam int ACC_W  = 32;   // accumulator and result
    localparam int VAL_W  = 8;    // activation and weight
    localparam int PROD_W = 16;   // 8 x 8 signed product
    localparam int SH_W   = 5;    // round shift
    localparam int CIDX_W = 2;    // configuration index
    localparam int CDAT_W = 11;   // configuration data

    // operation codes of an input beat
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BIAS   = 2'd1,
        OP_WEIGHT = 2'd2
    } t_op;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_VECTOR_LENGTH = 2'd0,
        CFG_NEURON_COUNT  = 2'd1,
        CFG_ROUND_SHIFT   = 2'd2,
        CFG_RELU_ENABLE   = 2'd3
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [LEN_W-1:0] vector_length;
        logic [LEN_W-1:0] neuron_count;
        logic [SH_W-1:0]  round_shift;
        logic             relu_enable;
    } t_cfg;

    // control that travels with a bias or weight beat down the pipeline
    typedef struct packed {
        logic              is_bias;
        logic              last_weight;
        logic [NPOS_W-1:0] neuron_number;
        logic              last_neuron;
    } t_ctl;

endpackage

// ----- rtl/core/i8fcl_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8fcl_store
// Activation store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module i8fcl_store (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [i8fcl_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic signed [i8fcl_pkg::VAL_W-1:0]  i_wr_data,
    input  logic                                i_rd_en,
    input  logic [i8fcl_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic signed [i8fcl_pkg::VAL_W-1:0]  o_rd_data
);

    logic signed [i8fcl_pkg::VAL_W-1:0] r_mem [i8fcl_pkg::MAX_VECTOR];
    logic signed [i8fcl_pkg::VAL_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/i8fcl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8fcl_seq
// Front-end sequencer: weight and neuron positions, read address and the
// control word of each accepted beat.
// ----------------------------------------------------------------------------
module i8fcl_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_op,
    input  i8fcl_pkg::t_cfg                i_cfg,
    output logic [i8fcl_pkg::ADDR_W-1:0]   o_rd_addr,
    output i8fcl_pkg::t_ctl                o_ctl
);

    localparam int LW = i8fcl_pkg::LEN_W;

    logic [i8fcl_pkg::ADDR_W-1:0] r_weight_pos, n_weight_pos;
    logic [i8fcl_pkg::NPOS_W-1:0] r_neuron_pos, n_neuron_pos;

    logic [LW-1:0]                len;
    logic [LW-1:0]                cnt;
    logic [i8fcl_pkg::ADDR_W-1:0] pos;
    logic [LW-1:0]                pos_inc;
    logic [LW-1:0]                npos_inc;
    logic                         last_w;
    logic                         last_n;

    // zero acts as one, large values saturate at the limit
    function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v,
                                                input logic [LW-1:0] hi);
        logic [LW-1:0] r;
        if (v == '0) begin
            r = LW'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // position arithmetic
    always_comb begin
        len      = clamp_len(i_cfg.vector_length, LW'(i8fcl_pkg::MAX_VECTOR));
        cnt      = clamp_len(i_cfg.neuron_count, LW'(i8fcl_pkg::MAX_NEURONS));
        pos      = ({1'b0, r_weight_pos} >= len) ? '0 : r_weight_pos;
        pos_inc  = {1'b0, pos} + LW'(1);
        last_w   = (pos_inc >= len);
        npos_inc = {1'b0, r_neuron_pos} + LW'(1);
        last_n   = (npos_inc >= cnt);
    end

    // next positions
    always_comb begin
        n_weight_pos = r_weight_pos;
        n_neuron_pos = r_neuron_pos;
        if (i_accept) begin
            case (i_op)
                i8fcl_pkg::OP_BIAS: begin
                    n_weight_pos = '0;
                end
                i8fcl_pkg::OP_WEIGHT: begin
                    if (last_w) begin
                        n_weight_pos = '0;
                        n_neuron_pos = last_n ? '0 : npos_inc[i8fcl_pkg::NPOS_W-1:0];
                    end else begin
                        n_weight_pos = pos_inc[i8fcl_pkg::ADDR_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_pos <= '0;
            r_neuron_pos <= '0;
        end else begin
            r_weight_pos <= n_weight_pos;
            r_neuron_pos <= n_neuron_pos;
        end
    end

    // control word for the beat being accepted
    always_comb begin
        o_rd_addr           = pos;
        o_ctl.is_bias       = (i_op == i8fcl_pkg::OP_BIAS);
        o_ctl.last_weight   = (i_op == i8fcl_pkg::OP_WEIGHT) && last_w;
        o_ctl.neuron_number = r_neuron_pos;
        o_ctl.last_neuron   = last_n;
    end

endmodule

// ----- rtl/core/i8fcl_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8fcl_mac
// Multiply-accumulate pipeline: beat register, product register and the
// accumulator with a finished-sum register.
// ----------------------------------------------------------------------------
module i8fcl_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  i8fcl_pkg::t_ctl                     i_ctl,
    input  logic signed [i8fcl_pkg::VAL_W-1:0]  i_weight,
    input  logic signed [i8fcl_pkg::ACC_W-1:0]  i_bias,
    input  logic signed [i8fcl_pkg::VAL_W-1:0]  i_act,
    input  logic                                i_take,
    output logic                                o_ready,
    output logic                                o_sum_valid,
    output logic [i8fcl_pkg::ACC_W-1:0]         o_sum,
    output i8fcl_pkg::t_ctl                     o_sum_ctl
);

    localparam int PW = i8fcl_pkg::PROD_W;
    localparam int AW = i8fcl_pkg::ACC_W;

    logic                                r1_valid;
    i8fcl_pkg::t_ctl                     r1_ctl;
    logic signed [i8fcl_pkg::VAL_W-1:0]  r1_weight;
    logic signed [AW-1:0]                r1_bias;

    logic                                r2_valid;
    i8fcl_pkg::t_ctl                     r2_ctl;
    logic signed [PW-1:0]                r2_prod;
    logic signed [AW-1:0]                r2_bias;

    logic                                r3_valid;
    i8fcl_pkg::t_ctl                     r3_ctl;
    logic [AW-1:0]                       r3_sum;
    logic [AW-1:0]                       r_acc;

    logic                                en1, en2, en3;
    logic [AW-1:0]                       sum;

    // stage enables, a stage moves when its successor has room
    always_comb begin
        en3 = !r3_valid || i_take;
        en2 = !r2_valid || en3;
        en1 = !r1_valid || en2;
        sum = r_acc + {{(AW-PW){r2_prod[PW-1]}}, r2_prod};
    end

    // beat register, aligned with the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_load) begin
            r1_ctl    <= i_ctl;
            r1_weight <= i_weight;
            r1_bias   <= i_bias;
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_ctl  <= r1_ctl;
            r2_prod <= i_act * r1_weight;
            r2_bias <= r1_bias;
        end
    end

    // accumulator, cleared after each finished neuron
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r_acc    <= '0;
        end else if (en3) begin
            r3_valid <= r2_valid && !r2_ctl.is_bias && r2_ctl.last_weight;
            if (r2_valid) begin
                if (r2_ctl.is_bias) begin
                    r_acc <= r2_bias;
                end else if (r2_ctl.last_weight) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid && r2_ctl.last_weight) begin
            r3_sum <= sum;
            r3_ctl <= r2_ctl;
        end
    end

    assign o_ready     = en1;
    assign o_sum_valid = r3_valid;
    assign o_sum       = r3_sum;
    assign o_sum_ctl   = r3_ctl;

endmodule

// ----- rtl/core/i8fcl_requant.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8fcl_requant
// Rounding shift and optional rectification into the result register.
// ----------------------------------------------------------------------------
module i8fcl_requant (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sum_valid,
    input  logic [i8fcl_pkg::ACC_W-1:0]         i_sum,
    input  i8fcl_pkg::t_ctl                     i_sum_ctl,
    input  i8fcl_pkg::t_cfg                     i_cfg,
    input  logic                                i_out_ready,
    output logic                                o_take,
    output logic                                o_out_valid,
    output logic signed [i8fcl_pkg::ACC_W-1:0]  o_neuron_result,
    output logic [i8fcl_pkg::NPOS_W-1:0]        o_neuron_number,
    output logic                                o_last_neuron
);

    localparam int AW = i8fcl_pkg::ACC_W;

    logic                         r_valid;
    logic signed [AW-1:0]         r_result;
    logic [i8fcl_pkg::NPOS_W-1:0] r_number;
    logic                         r_last;

    logic                         take;
    logic [AW-1:0]                rounded;
    logic signed [AW-1:0]         shifted;
    logic signed [AW-1:0]         n_result;

    // round half up, arithmetic shift, clamp negatives when enabled
    always_comb begin
        take    = i_sum_valid && (!r_valid || i_out_ready);
        rounded = i_sum + (AW'(1) << (i_cfg.round_shift - i8fcl_pkg::SH_W'(1)));
        shifted = $signed(rounded) >>> i_cfg.round_shift;
        if (i_cfg.round_shift == '0) begin
            n_result = $signed(i_sum);
        end else begin
            n_result = shifted;
        end
        if (i_cfg.relu_enable && n_result[AW-1]) begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
            r_number <= i_sum_ctl.neuron_number;
            r_last   <= i_sum_ctl.last_neuron;
        end
    end

    assign o_take          = take;
    assign o_out_valid     = r_valid;
    assign o_neuron_result = r_result;
    assign o_neuron_number = r_number;
    assign o_last_neuron   = r_last;

endmodule

// ----- rtl/core/int8_fully_connected_layer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_fully_connected_layer
// Int8 fully connected layer engine with requantization and optional ReLU.
// Activations are loaded into a 1024-entry store, then each neuron is a bias
// beat followed by vector_length weight beats; the last weight beat yields one
// result. The engine takes one input beat per cycle, limited by the single
// read port of the activation store (one read per beat), and keeps taking
// beats while a result waits in the output register until the pipeline
// behind it is full. The store has no reset; an activation must be loaded
// before use. The user writes configuration through its own port while the
// engine is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module int8_fully_connected_layer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i8fcl_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [i8fcl_pkg::CDAT_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic [i8fcl_pkg::ADDR_W-1:0]        i_element_index,
    input  logic signed [i8fcl_pkg::VAL_W-1:0]  i_small_value,
    input  logic signed [i8fcl_pkg::ACC_W-1:0]  i_bias_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [i8fcl_pkg::ACC_W-1:0]  o_neuron_result,
    output logic [i8fcl_pkg::NPOS_W-1:0]        o_neuron_number,
    output logic                                o_last_neuron
);

    i8fcl_pkg::t_cfg              r_cfg;
    logic                         in_accept;
    logic                         in_ready;
    logic                         mac_load;
    logic [i8fcl_pkg::ADDR_W-1:0] rd_addr;
    i8fcl_pkg::t_ctl              ctl;
    logic signed [i8fcl_pkg::VAL_W-1:0] act;
    logic                         sum_valid;
    logic [i8fcl_pkg::ACC_W-1:0]  sum;
    i8fcl_pkg::t_ctl              sum_ctl;
    logic                         take;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vector_length <= i8fcl_pkg::LEN_W'(1);
            r_cfg.neuron_count  <= i8fcl_pkg::LEN_W'(1);
            r_cfg.round_shift   <= '0;
            r_cfg.relu_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                i8fcl_pkg::CFG_VECTOR_LENGTH: r_cfg.vector_length <= i_cfg_data;
                i8fcl_pkg::CFG_NEURON_COUNT:  r_cfg.neuron_count  <= i_cfg_data;
                i8fcl_pkg::CFG_ROUND_SHIFT:
                    r_cfg.round_shift <= i_cfg_data[i8fcl_pkg::SH_W-1:0];
                i8fcl_pkg::CFG_RELU_ENABLE:   r_cfg.relu_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input beat handshake
    assign o_in_ready = in_ready;
    assign in_accept  = i_in_valid && in_ready;
    assign mac_load   = in_accept && ((i_operation == i8fcl_pkg::OP_BIAS) ||
                                      (i_operation == i8fcl_pkg::OP_WEIGHT));

    i8fcl_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_op      (i_operation),
        .i_cfg     (r_cfg),
        .o_rd_addr (rd_addr),
        .o_ctl     (ctl)
    );

    i8fcl_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && (i_operation == i8fcl_pkg::OP_LOAD)),
        .i_wr_addr (i_element_index),
        .i_wr_data (i_small_value),
        .i_rd_en   (mac_load),
        .i_rd_addr (rd_addr),
        .o_rd_data (act)
    );

    i8fcl_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (mac_load),
        .i_ctl       (ctl),
        .i_weight    (i_small_value),
        .i_bias      (i_bias_value),
        .i_act       (act),
        .i_take      (take),
        .o_ready     (in_ready),
        .o_sum_valid (sum_valid),
        .o_sum       (sum),
        .o_sum_ctl   (sum_ctl)
    );

    i8fcl_requant u_requant (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sum_valid     (sum_valid),
        .i_sum           (sum),
        .i_sum_ctl       (sum_ctl),
        .i_cfg           (r_cfg),
        .i_out_ready     (i_out_ready),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .o_neuron_result (o_neuron_result),
        .o_neuron_number (o_neuron_number),
        .o_last_neuron   (o_last_neuron)
    );

`ifndef SYNTH
    // the input side stalls only under result backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without result backpressure");

    // a finished sum is moved on whenever the result register frees up
    a_sum_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sum_valid && (!o_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("finished sum not moved to result register");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

// ----- bench/int8_fully_connected_layer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_fully_connected_layer_tb
// Self-checking bench for the int8 fully connected layer engine. A beat queue
// feeds a valid/ready driver, and a cycle-level predictor computes each neuron
// result as its beats are accepted. A short directed run covers wraparound,
// rounding overflow, ReLU, stray selectors, bias restarts and bias-free
// weights. Randomized phases follow, each with its own register setting and
// idle pattern, including an oversized vector length and a full neuron count.
// ----------------------------------------------------------------------------
module int8_fully_connected_layer_tb;

    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 400;

    // selector with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one input beat
    typedef struct packed {
        logic [1:0]                          op;
        logic [i8fcl_pkg::ADDR_W-1:0]        elem_idx;
        logic signed [i8fcl_pkg::VAL_W-1:0]  small_val;
        logic signed [i8fcl_pkg::ACC_W-1:0]  bias;
    } t_layer_beat;

    // one neuron result
    typedef struct packed {
        logic signed [i8fcl_pkg::ACC_W-1:0]  result;
        logic [i8fcl_pkg::NPOS_W-1:0]        number;
        logic                                last;
    } t_neuron_out;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [i8fcl_pkg::CIDX_W-1:0]        i_cfg_index = '0;
    logic [i8fcl_pkg::CDAT_W-1:0]        i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic [1:0]                          i_operation = '0;
    logic [i8fcl_pkg::ADDR_W-1:0]        i_element_index = '0;
    logic signed [i8fcl_pkg::VAL_W-1:0]  i_small_value = '0;
    logic signed [i8fcl_pkg::ACC_W-1:0]  i_bias_value = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [i8fcl_pkg::ACC_W-1:0]  o_neuron_result;
    logic [i8fcl_pkg::NPOS_W-1:0]        o_neuron_number;
    logic                                o_last_neuron;

    // stimulus side
    t_layer_beat                beat_q[$];
    bit                         act_loaded [i8fcl_pkg::MAX_VECTOR];
    logic                       beat_taken = 1'b0;
    int                         tx_idle_pct = 0;
    int                         rx_stall_pct = 0;
    bit                         hold_req = 1'b0;
    bit                         hold_done = 1'b0;
    int                         hold_left = 0;

    // predicted engine state and register copies
    logic [i8fcl_pkg::LEN_W-1:0]         vec_len_reg = 1;
    logic [i8fcl_pkg::LEN_W-1:0]         ncount_reg = 1;
    logic [i8fcl_pkg::SH_W-1:0]          shift_reg = '0;
    logic                                relu_reg = 1'b0;
    logic signed [i8fcl_pkg::VAL_W-1:0]  act_mem [i8fcl_pkg::MAX_VECTOR];
    logic [i8fcl_pkg::ACC_W-1:0]         acc = '0;
    int                                  weight_pos = 0;
    int                                  neuron_pos = 0;
    t_neuron_out                         expected_q[$];
    int                                  fail_count = 0;

    int8_fully_connected_layer uut (.*);

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // zero acts as one, anything above the limit saturates
    function automatic int eff_len(input logic [i8fcl_pkg::LEN_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // advance the predicted engine by one accepted beat
    task automatic accumulate_beat(input logic [1:0] op,
                                   input logic [i8fcl_pkg::ADDR_W-1:0] idx,
                                   input logic signed [i8fcl_pkg::VAL_W-1:0] v,
                                   input logic signed [i8fcl_pkg::ACC_W-1:0] b);
        int                                   len;
        int                                   cnt;
        int                                   pos;
        logic signed [i8fcl_pkg::PROD_W-1:0]  prod;
        logic signed [i8fcl_pkg::ACC_W-1:0]   r;
        logic                                 last;
        t_neuron_out                          e;
        case (op)
            i8fcl_pkg::OP_LOAD: act_mem[idx] = v;
            i8fcl_pkg::OP_BIAS: begin
                acc = b;
                weight_pos = 0;
            end
            i8fcl_pkg::OP_WEIGHT: begin
                len = eff_len(vec_len_reg, i8fcl_pkg::MAX_VECTOR);
                cnt = eff_len(ncount_reg, i8fcl_pkg::MAX_NEURONS);
                pos = (weight_pos >= len) ? 0 : weight_pos;
                prod = act_mem[pos] * v;
                acc = acc + {{(i8fcl_pkg::ACC_W-i8fcl_pkg::PROD_W){prod[i8fcl_pkg::PROD_W-1]}},
                             prod};
                pos++;
                if (pos < len) begin
                    weight_pos = pos;
                end else begin
                    // round half up, then arithmetic shift; the add wraps
                    r = acc;
                    if (shift_reg != 0) begin
                        r = r + (i8fcl_pkg::ACC_W'(1) << (shift_reg - 1));
                        r = r >>> shift_reg;
                    end
                    if (relu_reg && r[i8fcl_pkg::ACC_W-1])
                        r = '0;
                    last = (neuron_pos + 1 >= cnt);
                    e.result = r;
                    e.number = neuron_pos[i8fcl_pkg::NPOS_W-1:0];
                    e.last = last;
                    expected_q.push_back(e);
                    neuron_pos = last ? 0 : neuron_pos + 1;
                    weight_pos = 0;
                    acc = '0;
                end
            end
            default: ;  // stray selector is dropped
        endcase
    endtask

    // input driver
    always @(negedge i_clk) begin : drive_beats
        t_layer_beat nb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (beat_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                nb = beat_q.pop_front();
                i_in_valid <= 1'b1;
                i_operation <= nb.op;
                i_element_index <= nb.elem_idx;
                i_small_value <= nb.small_val;
                i_bias_value <= nb.bias;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLDOFF_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // monitor: predict on accepted input beats, check result beats
    always @(posedge i_clk) begin : check_results
        t_neuron_out want;
        beat_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            accumulate_beat(i_operation, i_element_index, i_small_value, i_bias_value);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, got %0d (neuron %0d)",
                         $realtime, o_neuron_result, o_neuron_number);
            end else begin
                want = expected_q.pop_front();
                if (o_neuron_result !== want.result) begin
                    fail_count++;
                    $display("%0t: neuron_result expected %0d, got %0d",
                             $realtime, want.result, o_neuron_result);
                end
                if (o_neuron_number !== want.number) begin
                    fail_count++;
                    $display("%0t: neuron_number expected %0d, got %0d",
                             $realtime, want.number, o_neuron_number);
                end
                if (o_last_neuron !== want.last) begin
                    fail_count++;
                    $display("%0t: last_neuron expected %0d, got %0d",
                             $realtime, want.last, o_last_neuron);
                end
            end
        end
    end

    // int8 value with the extremes favored
    function automatic logic signed [i8fcl_pkg::VAL_W-1:0] pick_small();
        case ($urandom_range(7, 0))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return '0;
            default: return i8fcl_pkg::VAL_W'($urandom());
        endcase
    endfunction

    // bias with the extremes favored
    function automatic logic signed [i8fcl_pkg::ACC_W-1:0] pick_bias();
        case ($urandom_range(7, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return i8fcl_pkg::ACC_W'(int'($urandom_range(2000, 0)) - 1000);
            default: return i8fcl_pkg::ACC_W'($urandom());
        endcase
    endfunction

    task automatic queue_beat(input logic [1:0] op, input int idx,
                              input logic signed [i8fcl_pkg::VAL_W-1:0] v,
                              input logic signed [i8fcl_pkg::ACC_W-1:0] b);
        t_layer_beat nb;
        nb.op = op;
        nb.elem_idx = idx[i8fcl_pkg::ADDR_W-1:0];
        nb.small_val = v;
        nb.bias = b;
        if (op == i8fcl_pkg::OP_LOAD)
            act_loaded[idx] = 1'b1;
        beat_q.push_back(nb);
    endtask

    // stray beat: unused selector, reload, restart or lone weight
    task automatic queue_noise();
        case ($urandom_range(3, 0))
            0: queue_beat(OP_UNUSED, $urandom_range(1023, 0), pick_small(), $urandom());
            1: queue_beat(i8fcl_pkg::OP_LOAD, $urandom_range(i8fcl_pkg::MAX_VECTOR - 1, 0),
                          pick_small(), $urandom());
            2: queue_beat(i8fcl_pkg::OP_BIAS, $urandom_range(1023, 0), pick_small(),
                          pick_bias());
            default: queue_beat(i8fcl_pkg::OP_WEIGHT, $urandom_range(1023, 0), pick_small(),
                                $urandom());
        endcase
    endtask

    // whole neurons with random content, never reading an unloaded activation
    task automatic queue_neurons(input int n, input int bias_pct, input int noise_pct);
        int len;
        int k;
        len = eff_len(vec_len_reg, i8fcl_pkg::MAX_VECTOR);
        if (n != 0)
            for (k = 0; k < len; k++)
                if (!act_loaded[k])
                    queue_beat(i8fcl_pkg::OP_LOAD, k, pick_small(), $urandom());
        repeat (n) begin
            if ($urandom_range(99, 0) < noise_pct)
                queue_noise();
            if ($urandom_range(99, 0) < bias_pct)
                queue_beat(i8fcl_pkg::OP_BIAS, $urandom_range(1023, 0), pick_small(),
                           pick_bias());
            for (k = 0; k < len; k++) begin
                if ($urandom_range(999, 0) < noise_pct)
                    queue_noise();
                queue_beat(i8fcl_pkg::OP_WEIGHT, $urandom_range(1023, 0), pick_small(),
                           $urandom());
            end
        end
    endtask

    // one register write beat; valid stays up for the next write
    task automatic write_reg(input i8fcl_pkg::t_cfg_idx idx,
                             input logic [i8fcl_pkg::CDAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            i8fcl_pkg::CFG_VECTOR_LENGTH: vec_len_reg = data;
            i8fcl_pkg::CFG_NEURON_COUNT:  ncount_reg = data;
            i8fcl_pkg::CFG_ROUND_SHIFT:   shift_reg = data[i8fcl_pkg::SH_W-1:0];
            i8fcl_pkg::CFG_RELU_ENABLE:   relu_reg = data[0];
            default: ;
        endcase
    endtask

    // block drained: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (beat_q.size() != 0 || i_in_valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [i8fcl_pkg::CDAT_W-1:0] len,
                             input logic [i8fcl_pkg::CDAT_W-1:0] cnt,
                             input logic [i8fcl_pkg::CDAT_W-1:0] sh,
                             input logic [i8fcl_pkg::CDAT_W-1:0] relu,
                             input int mode, input int n, input int bias_pct,
                             input int noise_pct, input bit hold_off);
        wait_idle();
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
            default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
        endcase
        write_reg(i8fcl_pkg::CFG_VECTOR_LENGTH, len);
        write_reg(i8fcl_pkg::CFG_NEURON_COUNT, cnt);
        write_reg(i8fcl_pkg::CFG_ROUND_SHIFT, sh);
        write_reg(i8fcl_pkg::CFG_RELU_ENABLE, relu);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (hold_off)
            hold_req = 1'b1;
        queue_neurons(n, bias_pct, noise_pct);
    endtask

    // stimulus
    initial begin
        int p;
        int k;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: bias-free weight, accumulator wrap both ways, stray selector
        queue_beat(i8fcl_pkg::OP_LOAD, 0, -8'sd128, $urandom());
        queue_beat(i8fcl_pkg::OP_LOAD, 1023, 8'sd127, $urandom());
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, -8'sd128, $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, 32'h7FFF_FFFF);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, -8'sd128, $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 1023, '0, 32'h8000_0000);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 1023, 8'sd127, $urandom());
        queue_beat(OP_UNUSED, 1023, 8'sd127, 32'hFFFF_FFFF);
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, -32'sd5);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, '0, $urandom());

        // zero length, rounding add that overflows
        run_phase(0, 2, 1, 0, 0, 0, 0, 0, 1'b0);
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, 32'h7FFF_FFFF);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, '0, $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, -32'sd3);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, '0, $urandom());

        // widest shift with relu, bias restart in mid-neuron
        run_phase(3, 0, 31, 1, 3, 0, 0, 0, 1'b0);
        queue_beat(i8fcl_pkg::OP_LOAD, 1, 8'sd5, $urandom());
        queue_beat(i8fcl_pkg::OP_LOAD, 2, -8'sd7, $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, 32'sd100);
        queue_beat(i8fcl_pkg::OP_WEIGHT, 0, 8'sd3, $urandom());
        queue_beat(OP_UNUSED, 0, '0, '0);
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, 32'h4000_0000);
        repeat (3) queue_beat(i8fcl_pkg::OP_WEIGHT, 0, 8'sd1, $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, -32'sd1000);
        repeat (3) queue_beat(i8fcl_pkg::OP_WEIGHT, 0, 8'sd1, $urandom());

        // full neuron count with a long result hold-off
        run_phase(1, 2047, 3, 1, 0, 1030, 5, 2, 1'b1);
        // count lowered below the current neuron position
        run_phase(3, 5, 2, 1, 1, 12, 90, 10, 1'b0);
        run_phase(2, 1024, 0, 0, 2, 10, 90, 10, 1'b0);
        // oversized length saturates, neuron left open
        run_phase(2047, 1, 5, 1, 3, 0, 0, 0, 1'b0);
        for (k = 0; k < 20; k++)
            if (!act_loaded[k])
                queue_beat(i8fcl_pkg::OP_LOAD, k, pick_small(), $urandom());
        queue_beat(i8fcl_pkg::OP_BIAS, 0, '0, pick_bias());
        for (k = 0; k < 20; k++)
            queue_beat(i8fcl_pkg::OP_WEIGHT, $urandom_range(1023, 0), pick_small(),
                       $urandom());
        // weight position left past the new length
        run_phase(4, 3, 1, 0, 0, 10, 90, 10, 1'b0);

        for (p = 0; p < 6; p++)
            run_phase(i8fcl_pkg::CDAT_W'($urandom_range(12, 0)),
                      i8fcl_pkg::CDAT_W'($urandom_range(9, 0)),
                      i8fcl_pkg::CDAT_W'($urandom()), i8fcl_pkg::CDAT_W'($urandom()),
                      p % 4, $urandom_range(12, 4), 90, 10, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/i8fcl_pkg.sv
rtl/core/i8fcl_store.sv
rtl/core/i8fcl_seq.sv
rtl/core/i8fcl_mac.sv
rtl/core/i8fcl_requant.sv
rtl/core/int8_fully_connected_layer.sv
bench/int8_fully_connected_layer_tb.sv
